>>> rtl/ckst_pkg.sv
// Shared types and constants for the counted key set table.
package ckst_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    ACT_CHECK = 2'd0,
    ACT_PUSH  = 2'd1,
    ACT_PULL  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic [CNT_W-1:0] count;
    status_e          status;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
  } token_t;

endpackage

>>> rtl/counted_key_set_table_core.sv
// Counted key set table: a chain of slot cells walked by one request word.
// Each cell registers the passing word; the tail result is registered into the outputs.
// A new word is taken only while busy is low; the word visits one cell per cycle.
// A claim of a free slot on push is written at the edge the word leaves the chain.
// Reset clears all keys and counts to zero and drops busy and done_o.
// done_o marks each result for one cycle; the receiver cannot stall it.
module counted_key_set_table_core import ckst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [CNT_W-1:0] count_o,
  output logic [1:0]       status_o
);

  token_t           tok [ENTRIES+1];
  logic [ENTRIES-1:0] claim;
  token_t           tail;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] count_q, count_d;
  status_e          status_q, status_d;
  logic             do_claim;

  always_comb begin
    tok[0].valid    = start && !busy_q;
    tok[0].action   = action_i;
    tok[0].key      = key_i;
    tok[0].hit      = 1'b0;
    tok[0].count    = '0;
    tok[0].status   = ST_OK;
    tok[0].free_hit = 1'b0;
    tok[0].free_idx = '0;
  end

  assign tail = tok[ENTRIES];

  always_comb begin
    do_claim = 1'b0;
    count_d  = '0;
    status_d = ST_NOT_FOUND;
    if (tail.hit) begin
      count_d  = tail.count;
      status_d = tail.status;
    end else if (tail.action == ACT_PUSH) begin
      if (tail.free_hit) begin
        do_claim = tail.valid;
        count_d  = CNT_W'(1);
        status_d = ST_OK;
      end else begin
        status_d = ST_FULL;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      claim[j] = do_claim && (tail.free_idx == IDX_W'(j));
    end
  end

  genvar i;
  generate
    for (i = 0; i < ENTRIES; i++) begin : g_cell
      ckst_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .idx_i       (IDX_W'(i)),
        .tok_i       (tok[i]),
        .claim_i     (claim[i]),
        .claim_key_i (tail.key),
        .tok_o       (tok[i+1])
      );
    end
  endgenerate

  always_comb begin
    busy_d = busy_q;
    if (tok[0].valid) begin
      busy_d = 1'b1;
    end else if (tail.valid) begin
      busy_d = 1'b0;
    end
    done_d = tail.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid) begin
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  assign busy     = busy_q;
  assign done_o   = done_q;
  assign count_o  = count_q;
  assign status_o = status_q;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe repeated");
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (count_o == '0))
    else $error("full result with nonzero count");
`endif

endmodule

>>> rtl/ckst_cell.sv
// One table slot: holds a key and count, serves the passing request word.
module ckst_cell import ckst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  token_t           tok_i,
  input  logic             claim_i,
  input  logic [KEY_W-1:0] claim_key_i,
  output token_t           tok_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  token_t           tok_d;
  logic             match;

  assign match = tok_i.valid && !tok_i.hit && (key_q == tok_i.key);

  always_comb begin
    key_d = key_q;
    cnt_d = cnt_q;
    tok_d = tok_i;
    if (match) begin
      tok_d.hit    = 1'b1;
      tok_d.status = ST_OK;
      case (tok_i.action)
        ACT_PUSH: begin
          if (cnt_q != '1) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          tok_d.count = cnt_d;
        end
        ACT_PULL: begin
          if (cnt_q != '0) begin
            cnt_d       = cnt_q - CNT_W'(1);
            tok_d.count = cnt_d;
          end else begin
            key_d        = '0;
            tok_d.count  = '0;
            tok_d.status = ST_NOT_FOUND;
          end
        end
        default: begin
          tok_d.count = cnt_q;
        end
      endcase
    end
    if (tok_i.valid && !tok_i.free_hit && (cnt_q == '0)) begin
      tok_d.free_hit = 1'b1;
      tok_d.free_idx = idx_i;
    end
    if (claim_i) begin
      key_d = claim_key_i;
      cnt_d = CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      cnt_q <= '0;
      tok_o <= '0;
    end else begin
      key_q <= key_d;
      cnt_q <= cnt_d;
      tok_o <= tok_d;
    end
  end

endmodule

>>> dv/tb.sv
// Self-checking testbench for the counted key set table: directed rows, then random words.
module tb;
  import ckst_pkg::*;

  localparam logic [1:0]       ACT_SPARE = 2'd3;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam int               POOL      = 24;
  localparam int               RAND_WORDS = 360;

  typedef struct {
    logic [CNT_W-1:0] count;
    status_e          status;
  } tally_t;

  typedef struct {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
    int unsigned      reps;
    logic [KEY_W-1:0] key_step;
    bit               typed;
    logic [CNT_W-1:0] count;
    status_e          status;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       action_i;
  logic [KEY_W-1:0] key_i;
  logic             done_o;
  logic [CNT_W-1:0] count_o;
  logic [1:0]       status_o;

  logic [KEY_W-1:0] slot_key   [ENTRIES];
  logic [CNT_W-1:0] slot_count [ENTRIES];
  logic [KEY_W-1:0] key_pool   [POOL];
  tally_t           expected_tallies[$];
  stim_row_t        directed_rows[$];
  tally_t           oldest_tally;
  int unsigned      fault_count;
  bit               quiet;

  counted_key_set_table_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .action_i(action_i),
    .key_i   (key_i),
    .done_o  (done_o),
    .count_o (count_o),
    .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("[counted_key_set_table_core] ERROR");
    $finish;
  end

  function automatic void tally_word(input logic [1:0] act, input logic [KEY_W-1:0] k,
                                     output tally_t tally);
    int i;
    int hit_idx;
    int free_idx;
    hit_idx  = -1;
    free_idx = -1;
    for (i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_key[i] == k) hit_idx = i;
      if (slot_count[i] == '0) free_idx = i;
    end
    tally.count  = '0;
    tally.status = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (hit_idx >= 0) begin
          if (slot_count[hit_idx] != CNT_MAX) slot_count[hit_idx] = slot_count[hit_idx] + 1'b1;
          tally.count = slot_count[hit_idx];
        end else if (free_idx >= 0) begin
          slot_key[free_idx]   = k;
          slot_count[free_idx] = CNT_W'(1);
          tally.count          = CNT_W'(1);
        end else begin
          tally.status = ST_FULL;
        end
      end
      ACT_PULL: begin
        if (hit_idx >= 0 && slot_count[hit_idx] != '0) begin
          slot_count[hit_idx] = slot_count[hit_idx] - 1'b1;
          tally.count         = slot_count[hit_idx];
        end else begin
          if (hit_idx >= 0) slot_key[hit_idx] = '0;
          tally.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit_idx >= 0) tally.count = slot_count[hit_idx];
        else tally.status = ST_NOT_FOUND;
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic void add_row(input logic [1:0] act, input logic [KEY_W-1:0] k,
                                  input int unsigned reps, input logic [KEY_W-1:0] step,
                                  input bit typed, input logic [CNT_W-1:0] cnt,
                                  input status_e st);
    stim_row_t row;
    row.action   = act;
    row.key      = k;
    row.reps     = reps;
    row.key_step = step;
    row.typed    = typed;
    row.count    = cnt;
    row.status   = st;
    directed_rows.push_back(row);
  endfunction

  task automatic send_word(input logic [1:0] act, input logic [KEY_W-1:0] k, input bit typed,
                           input logic [CNT_W-1:0] cnt, input status_e st);
    int unsigned gap;
    tally_t      tally;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    action_i <= act;
    key_i    <= k;
    do @(posedge clk_i); while (busy);
    tally_word(act, k, tally);
    if (typed) begin
      tally.count  = cnt;
      tally.status = st;
    end
    expected_tallies.push_back(tally);
  endtask

  task automatic drain_tallies();
    start <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_tallies.size() == 0) begin
        if (fault_count < 10) begin
          $display("unexpected word: count %0d status %0d", count_o, status_o);
        end
        fault_count++;
      end else begin
        oldest_tally = expected_tallies.pop_front();
        if (count_o !== oldest_tally.count || status_o !== oldest_tally.status) begin
          if (fault_count < 10) begin
            $display("word mismatch: count exp %0d got %0d, status exp %0d got %0d",
                     oldest_tally.count, count_o, oldest_tally.status, status_o);
          end
          fault_count++;
        end
      end
    end
  end

  initial begin
    int unsigned      n;
    int unsigned      r;
    int unsigned      rep;
    logic [1:0]       act;
    logic [KEY_W-1:0] k;
    start       <= 1'b0;
    action_i    <= ACT_CHECK;
    key_i       <= '0;
    rst_ni      <= 1'b0;
    fault_count = 0;
    quiet       = 1'b0;
    for (n = 0; n < ENTRIES; n++) begin
      slot_key[n]   = '0;
      slot_count[n] = '0;
    end
    for (n = 0; n < POOL; n++) begin
      if (n < 14) key_pool[n] = 32'h8000_0000 + n * 32'h0101_0101;
      else if (n == 14) key_pool[n] = '0;
      else key_pool[n] = $urandom;
    end

    add_row(ACT_CHECK, 32'h0000_0000, 1, '0, 1, 0, ST_OK);
    add_row(ACT_CHECK, 32'hDEAD_BEEF, 1, '0, 1, 0, ST_NOT_FOUND);
    add_row(ACT_PULL,  32'hFFFF_FFFF, 1, '0, 1, 0, ST_NOT_FOUND);
    add_row(ACT_PUSH,  32'hFFFF_FFFF, 1, '0, 1, 1, ST_OK);
    add_row(ACT_PUSH,  32'hFFFF_FFFF, 1, '0, 0, 0, ST_OK);
    add_row(ACT_SPARE, 32'hFFFF_FFFF, 1, '0, 0, 0, ST_OK);
    add_row(ACT_PULL,  32'hFFFF_FFFF, 2, '0, 0, 0, ST_OK);
    add_row(ACT_PULL,  32'hFFFF_FFFF, 1, '0, 1, 0, ST_NOT_FOUND);
    add_row(ACT_CHECK, 32'hFFFF_FFFF, 1, '0, 1, 0, ST_NOT_FOUND);
    add_row(ACT_PUSH,  32'h0000_0000, 1, '0, 0, 0, ST_OK);
    add_row(ACT_PUSH,  32'h5A5A_A5A5, 8, '0, 0, 0, ST_OK);
    add_row(ACT_PUSH,  32'h5A5A_A5A5, 1, '0, 0, 0, ST_OK);
    add_row(ACT_PULL,  32'h5A5A_A5A5, 1, '0, 0, 0, ST_OK);
    add_row(ACT_PUSH,  32'h8000_0000, 14, 32'h0101_0101, 0, 0, ST_OK);
    add_row(ACT_PUSH,  32'h0000_0001, 1, '0, 1, 0, ST_FULL);
    add_row(ACT_CHECK, 32'h0000_0001, 1, '0, 1, 0, ST_NOT_FOUND);
    add_row(ACT_PULL,  32'h0000_0001, 1, '0, 1, 0, ST_NOT_FOUND);
    add_row(ACT_CHECK, 32'h8D0D_0D0D, 1, '0, 0, 0, ST_OK);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      quiet = directed_rows[i].reps > 1;
      for (rep = 0; rep < directed_rows[i].reps; rep++) begin
        send_word(directed_rows[i].action,
                  directed_rows[i].key + rep * directed_rows[i].key_step,
                  directed_rows[i].typed, directed_rows[i].count, directed_rows[i].status);
      end
    end

    for (n = 0; n < RAND_WORDS; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(3) == 0);
      if (n == RAND_WORDS / 2) drain_tallies();
      r = $urandom_range(99);
      if (r < 40) act = ACT_PUSH;
      else if (r < 80) act = ACT_PULL;
      else if (r < 95) act = ACT_CHECK;
      else act = ACT_SPARE;
      r = $urandom_range(99);
      if (r < 80) k = key_pool[$urandom_range(POOL - 1)];
      else if (r < 90) k = $urandom;
      else k = '0;
      send_word(act, k, 0, '0, ST_OK);
    end

    drain_tallies();
    repeat (ENTRIES + 4) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("[counted_key_set_table_core] OK");
    end else begin
      $display("[counted_key_set_table_core] ERROR");
    end
    $finish;
  end

endmodule

>>> counted_key_set_table_core.f
rtl/ckst_pkg.sv
rtl/ckst_cell.sv
rtl/counted_key_set_table_core.sv
dv/tb.sv
